// File: hdl/tepq_pkg.sv
// tepq_pkg: shared types and constants for the timed event priority queue
// used by the channel interfaces, the queue cell and the top level
package tepq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int TRIG_DEPTH  = 16;
  localparam int SRC_W       = 10;
  localparam int TIME_W      = 64;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 3;
  localparam int KIND_W      = 2;
  localparam int COUNT_W     = $clog2(QUEUE_DEPTH + 1);
  localparam int TCOUNT_W    = $clog2(TRIG_DEPTH + 1);
  localparam int TIDX_W      = (TRIG_DEPTH > 1) ? $clog2(TRIG_DEPTH) : 1;

  typedef enum logic [OP_W-1:0] {
    OP_SCHED      = 3'd0,
    OP_POP        = 3'd1,
    OP_CANCEL_ALL = 3'd2,
    OP_CANCEL_ONE = 3'd3,
    OP_PUSH_TRIG  = 3'd4,
    OP_RESCHED    = 3'd5
  } tepq_op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DROPPED  = 3'd1,
    ST_FULL     = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4,
    ST_PAST     = 3'd5
  } tepq_status_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_NONE  = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_TRIG  = 2'd2
  } tepq_kind_t;

  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_SHIFT  = 2'd2
  } tepq_cmd_t;

  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] tm;
    logic [SRC_W-1:0]  src;
  } tepq_ent_t;

  // broadcast to every cell: item is the new entry for insert, the
  // appended entry for a shift with app_en set
  typedef struct packed {
    tepq_cmd_t cmd;
    logic      app_en;
    tepq_ent_t item;
  } tepq_ctl_t;

endpackage

// File: hdl/tepq_in_if.sv
// tepq_in_if: input item channel of the timed event priority queue
// depends on tepq_pkg
interface tepq_in_if import tepq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [TIME_W-1:0] event_time;
  logic [SRC_W-1:0]  source_id;

  modport source (output valid, operation, event_time, source_id, input ready);
  modport sink (input valid, operation, event_time, source_id, output ready);
endinterface

// File: hdl/tepq_out_if.sv
// tepq_out_if: result item channel of the timed event priority queue
// depends on tepq_pkg
interface tepq_out_if import tepq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [KIND_W-1:0]   served_kind;
  logic [TIME_W-1:0]   served_time;
  logic [SRC_W-1:0]    served_source;
  logic [COUNT_W-1:0]  removed_count;

  modport source (output valid, status, served_kind, served_time, served_source,
                  removed_count, input ready);
  modport sink (input valid, status, served_kind, served_time, served_source,
                removed_count, output ready);
endinterface

// File: hdl/tepq_cell.sv
// tepq_cell: one slot of the sorted queue chain
// depends on tepq_pkg; talks to its two neighbors and takes the broadcast control
module tepq_cell import tepq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tepq_ctl_t ctl,
  input  tepq_ent_t left_ent,
  input  logic      left_take,
  input  tepq_ent_t right_ent,
  output tepq_ent_t ent_o,
  output logic      take_o
);

  tepq_ent_t ent_r, ent_nxt;

  // slot is at or beyond the insertion point (equal times stay ahead)
  assign take_o = !ent_r.valid || (ent_r.tm > ctl.item.tm);
  assign ent_o  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    case (ctl.cmd)
      CMD_INSERT: begin
        if (left_take) begin
          ent_nxt = left_ent;
        end else if (take_o) begin
          ent_nxt = ctl.item;
        end
      end
      CMD_SHIFT: begin
        // tail slot takes the appended entry, all others move toward head
        if (ctl.app_en && ent_r.valid && !right_ent.valid) begin
          ent_nxt = ctl.item;
        end else begin
          ent_nxt = right_ent;
        end
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// File: hdl/timed_event_priority_queue.sv
// timed_event_priority_queue: event scheduler top level
// depends on tepq_pkg, tepq_in_if, tepq_out_if and tepq_cell
//
// usage:
// - in_ch carries one operation item (operation, event_time, source_id);
//   out_ch returns exactly one result item per operation
// - cfg_we / cfg_wdata write end_time; write only while the block is idle
// - schedule, pop and push trigger finish at the accept edge: the result
//   is valid the next cycle, one item per cycle sustained while out_ch is ready
// - cancel all, cancel exact and reschedule rotate the whole queue once
//   through the cell chain, one shift per pending event, where the head
//   cell is examined once per cycle
// - the queue is a row of cells sorted by time; insert and pop are one
//   parallel shift across all cells
// - reset (rst_n low, synchronous) empties the queue and the trigger stack,
//   clears current time and end_time; no clearing pass is needed
// - when out_ch stalls, the result waits in the output register and no
//   new item is accepted until it is taken or taken in the same cycle
module timed_event_priority_queue import tepq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  tepq_in_if.sink           in_ch,
  tepq_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t state_r, state_nxt;

  // architectural state
  logic [TIME_W-1:0]   end_time_r;
  logic [TIME_W-1:0]   cur_time_r, cur_time_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [TCOUNT_W-1:0] tcnt_r, tcnt_nxt;
  logic [SRC_W-1:0]    trig_mem [TRIG_DEPTH];
  logic                trig_we;

  // latched operation for multi-cycle scans
  tepq_op_t            op_r, op_nxt;
  logic [TIME_W-1:0]   t_r, t_nxt;
  logic [SRC_W-1:0]    src_r, src_nxt;
  logic [COUNT_W-1:0]  left_r, left_nxt;
  logic [COUNT_W-1:0]  rem_r, rem_nxt;
  logic                found_r, found_nxt;

  // output register
  logic                out_valid_r, out_valid_nxt;
  tepq_status_t        status_r, status_nxt;
  tepq_kind_t          kind_r, kind_nxt;
  logic [TIME_W-1:0]   stime_r, stime_nxt;
  logic [SRC_W-1:0]    ssrc_r, ssrc_nxt;
  logic [COUNT_W-1:0]  rcnt_r, rcnt_nxt;

  // cell chain
  tepq_ctl_t           ctl;
  tepq_ent_t           ent [QUEUE_DEPTH];
  logic                take [QUEUE_DEPTH];
  tepq_ent_t           head;
  logic                accept, out_take, drop;
  tepq_status_t        chk;
  logic [TIME_W-1:0]   chk_t;
  logic [TIDX_W-1:0]   tidx;
  tepq_op_t            in_op;

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      tepq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .left_ent  ((g == 0) ? tepq_ent_t'('0) : ent[(g == 0) ? 0 : g - 1]),
        .left_take ((g == 0) ? 1'b0 : take[(g == 0) ? 0 : g - 1]),
        .right_ent ((g == QUEUE_DEPTH - 1) ? tepq_ent_t'('0)
                    : ent[(g == QUEUE_DEPTH - 1) ? g : g + 1]),
        .ent_o     (ent[g]),
        .take_o    (take[g])
      );
    end
  endgenerate

  assign head     = ent[0];
  assign in_op    = tepq_op_t'(in_ch.operation);
  assign in_ch.ready = (state_r == S_IDLE) && (!out_valid_r || out_ch.ready);
  assign accept   = in_ch.valid && in_ch.ready;
  assign out_take = out_valid_r && out_ch.ready;
  assign tidx     = TIDX_W'(tcnt_r - 1'b1);

  // schedule checks: past before end, end before full
  assign chk_t = (state_r == S_IDLE) ? in_ch.event_time : t_r;
  always_comb begin
    if (chk_t < cur_time_r) begin
      chk = ST_PAST;
    end else if ((end_time_r != '0) && (chk_t >= end_time_r)) begin
      chk = ST_DROPPED;
    end else if (cnt_r == COUNT_W'(QUEUE_DEPTH)) begin
      chk = ST_FULL;
    end else begin
      chk = ST_OK;
    end
  end

  // head matches during a scan: cancel exact drops only the first match
  always_comb begin
    if (op_r == OP_CANCEL_ONE) begin
      drop = !found_r && (head.src == src_r) && (head.tm == t_r);
    end else begin
      drop = (head.src == src_r);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cur_time_nxt  = cur_time_r;
    cnt_nxt       = cnt_r;
    tcnt_nxt      = tcnt_r;
    trig_we       = 1'b0;
    op_nxt        = op_r;
    t_nxt         = t_r;
    src_nxt       = src_r;
    left_nxt      = left_r;
    rem_nxt       = rem_r;
    found_nxt     = found_r;
    out_valid_nxt = out_valid_r && !out_take;
    status_nxt    = status_r;
    kind_nxt      = kind_r;
    stime_nxt     = stime_r;
    ssrc_nxt      = ssrc_r;
    rcnt_nxt      = rcnt_r;
    ctl.cmd       = CMD_HOLD;
    ctl.app_en    = 1'b0;
    ctl.item      = '{valid: 1'b1, tm: in_ch.event_time, src: in_ch.source_id};

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ST_OK;
          kind_nxt      = KIND_NONE;
          stime_nxt     = '0;
          ssrc_nxt      = '0;
          rcnt_nxt      = '0;
          case (in_op)
            OP_SCHED: begin
              status_nxt = chk;
              if (chk == ST_OK) begin
                ctl.cmd = CMD_INSERT;
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            OP_POP: begin
              if (tcnt_r != '0) begin
                tcnt_nxt  = tcnt_r - 1'b1;
                kind_nxt  = KIND_TRIG;
                stime_nxt = cur_time_r;
                ssrc_nxt  = trig_mem[tidx];
              end else if (cnt_r != '0) begin
                kind_nxt     = KIND_EVENT;
                stime_nxt    = head.tm;
                ssrc_nxt     = head.src;
                cur_time_nxt = head.tm;
                ctl.cmd      = CMD_SHIFT;
                cnt_nxt      = cnt_r - 1'b1;
              end else begin
                status_nxt = ST_EMPTY;
              end
            end
            OP_CANCEL_ALL, OP_CANCEL_ONE, OP_RESCHED: begin
              out_valid_nxt = 1'b0;
              state_nxt     = S_SCAN;
              op_nxt        = in_op;
              t_nxt         = in_ch.event_time;
              src_nxt       = in_ch.source_id;
              left_nxt      = cnt_r;
              rem_nxt       = '0;
              found_nxt     = 1'b0;
            end
            OP_PUSH_TRIG: begin
              if (tcnt_r == TCOUNT_W'(TRIG_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                trig_we  = 1'b1;
                tcnt_nxt = tcnt_r + 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (left_r != '0) begin
          // rotate: head leaves, kept entries rejoin at the tail
          ctl.cmd    = CMD_SHIFT;
          ctl.app_en = !drop;
          ctl.item   = head;
          left_nxt   = left_r - 1'b1;
          if (drop) begin
            rem_nxt   = rem_r + 1'b1;
            found_nxt = 1'b1;
            cnt_nxt   = cnt_r - 1'b1;
          end
        end else begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          kind_nxt      = KIND_NONE;
          stime_nxt     = '0;
          ssrc_nxt      = '0;
          rcnt_nxt      = rem_r;
          status_nxt    = ST_OK;
          if (op_r == OP_CANCEL_ONE) begin
            status_nxt = found_r ? ST_OK : ST_NOTFOUND;
          end else if (op_r == OP_RESCHED) begin
            status_nxt = chk;
            ctl.item   = '{valid: 1'b1, tm: t_r, src: src_r};
            if (chk == ST_OK) begin
              ctl.cmd = CMD_INSERT;
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      end_time_r  <= '0;
      cur_time_r  <= '0;
      cnt_r       <= '0;
      tcnt_r      <= '0;
      out_valid_r <= 1'b0;
      op_r        <= OP_SCHED;
      left_r      <= '0;
      rem_r       <= '0;
      found_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        end_time_r <= cfg_wdata;
      end
      cur_time_r  <= cur_time_nxt;
      cnt_r       <= cnt_nxt;
      tcnt_r      <= tcnt_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
      left_r      <= left_nxt;
      rem_r       <= rem_nxt;
      found_r     <= found_nxt;
    end
    t_r      <= t_nxt;
    src_r    <= src_nxt;
    status_r <= status_nxt;
    kind_r   <= kind_nxt;
    stime_r  <= stime_nxt;
    ssrc_r   <= ssrc_nxt;
    rcnt_r   <= rcnt_nxt;
  end

  // trigger stack
  always_ff @(posedge clk) begin
    if (trig_we) begin
      trig_mem[TIDX_W'(tcnt_r)] <= in_ch.source_id;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = status_r;
  assign out_ch.served_kind   = kind_r;
  assign out_ch.served_time   = stime_r;
  assign out_ch.served_source = ssrc_r;
  assign out_ch.removed_count = rcnt_r;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_W'(QUEUE_DEPTH)) else $error("queue count overflow");
  a_tcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    tcnt_r <= TCOUNT_W'(TRIG_DEPTH)) else $error("trigger count overflow");
  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN |-> !in_ch.ready) else $error("accept during scan");
  a_scan_removes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SCAN && left_r != '0 && drop |=> cnt_r == $past(cnt_r) - 1'b1)
    else $error("scan drop lost");
`endif

endmodule
